### hw/rtl/ljpf_pkg.sv
// Shared types, constants and saturating helpers for the Lennard-Jones pair force block.
// No dependencies; imported by the top level and its arithmetic units.
`timescale 1ns / 1ps
`default_nettype none

package ljpf_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA          = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQUARED = 8'd3;

  localparam logic [31:0] BOX_LENGTH_RST = 32'd655360;
  localparam logic [31:0] SIGMA_RST      = 32'd65536;
  localparam logic [31:0] EPSILON_RST    = 32'd65536;
  localparam logic [31:0] CUTOFF_SQ_RST  = 32'd409600;

  localparam logic [63:0] U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_X2    = U64_MAX / 2;
  localparam logic [63:0] LIM_X4    = U64_MAX / 4;
  localparam logic [63:0] LIM_X24   = U64_MAX / 24;
  localparam logic [47:0] FORCE_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN_U = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_SQ,
    ST_CHK,
    ST_S2,
    ST_DIV1,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_EN,
    ST_FM,
    ST_DIV2,
    ST_FRC,
    ST_DONE
  } ljpf_state_e;

  // fixed point product, floored after the fraction shift, saturating
  function automatic logic [63:0] mulq_sat(input logic [127:0] p);
    if (p[127:64+FRAC_BITS] != '0) begin
      return U64_MAX;
    end
    return p[64+FRAC_BITS-1:FRAC_BITS];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? U64_MAX : s[63:0];
  endfunction

  function automatic logic [63:0] sat_x2(input logic [63:0] v);
    return (v > LIM_X2) ? U64_MAX : {v[62:0], 1'b0};
  endfunction

  function automatic logic [63:0] sat_x4(input logic [63:0] v);
    return (v > LIM_X4) ? U64_MAX : {v[61:0], 2'b00};
  endfunction

  function automatic logic [63:0] sat_x24(input logic [63:0] v);
    return (v > LIM_X24) ? U64_MAX : ({v[59:0], 4'b0} + {v[60:0], 3'b0});
  endfunction

  // saturating signed accumulate of a signed magnitude
  function automatic logic [63:0] energy_add(input logic [63:0] acc, input logic neg,
                                             input logic [63:0] m);
    logic [63:0] mc;
    logic [65:0] r;
    mc = (m > I64_MIN_U) ? I64_MIN_U : m;
    if (neg) begin
      r = {{2{acc[63]}}, acc} - {2'b00, mc};
    end else begin
      r = {{2{acc[63]}}, acc} + {2'b00, mc};
    end
    if (!r[65] && r[64:63] != 2'b00) begin
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end
    if (r[65] && r[64:63] != 2'b11) begin
      return I64_MIN_U;
    end
    return r[63:0];
  endfunction

  function automatic logic [47:0] force_word(input logic neg, input logic [63:0] m);
    logic [63:0] mc;
    if (!neg) begin
      return (m > {16'b0, FORCE_MAX}) ? FORCE_MAX : m[47:0];
    end
    mc = (m > {16'b0, FORCE_MAX} + 64'd1) ? ({16'b0, FORCE_MAX} + 64'd1) : m;
    return 48'(64'd0 - mc);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ljpf_mul.sv
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier used for four partial products in turn.
// Uses ljpf_pkg; instantiated by lennard_jones_pair_force.
`timescale 1ns / 1ps
`default_nettype none

module ljpf_mul
  import ljpf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  logic [63:0]  a_q, b_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [63:0]  pp_q;
  logic [63:0]  pp_d;
  logic [1:0]   pk_q;
  logic [127:0] acc_q;
  logic [127:0] pp_sh;
  logic [31:0]  ah, bh;

  // partial product order: a0b0, a0b1, a1b0, a1b1
  always_comb begin
    ah   = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    bh   = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp_d = 64'(ah) * 64'(bh);
    unique case (pk_q)
      2'd0:    pp_sh = {64'b0, pp_q};
      2'd3:    pp_sh = {pp_q, 64'b0};
      default: pp_sh = {32'b0, pp_q, 32'b0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= pp_d;
        pk_q <= cnt_q[1:0];
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

### hw/rtl/ljpf_div.sv
// Radix-2 restoring divider: 128-bit numerator by 64-bit divisor, one bit a cycle.
// Uses ljpf_pkg; instantiated by lennard_jones_pair_force.
`timescale 1ns / 1ps
`default_nettype none

module ljpf_div
  import ljpf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_hi_i,
  input  wire logic [63:0] num_lo_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  logic [63:0] rem_q, lo_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        take;

  always_comb begin
    shifted = {rem_q, lo_q[63]};
    diff    = shifted - {1'b0, den_q};
    take    = (shifted >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den_i == '0 || num_hi_i >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi_i;
      lo_q  <= num_lo_i;
      den_q <= den_i;
      quo_q <= (den_i == '0 || num_hi_i >= den_i) ? U64_MAX : '0;
    end else if (busy_q) begin
      lo_q  <= {lo_q[62:0], 1'b0};
      rem_q <= take ? diff[63:0] : shifted[63:0];
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### hw/rtl/lennard_jones_pair_force.sv
// Lennard-Jones pair force with cutoff: sequencer, register file and result stage.
// Depends on ljpf_pkg, ljpf_mul and ljpf_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tdata: first_x, first_y, first_z, second_x, second_y, second_z;
//                tlast: last_pair
// m_axis    out  tdata: force_x, force_y, force_z, energy_total; tuser: within_cutoff;
//                tlast: end_of_pass
// cfg       in   cfg_index_i: register, cfg_data_i: value; always ready
//
// A pair in range passes from its accepting edge to the result beat, then back to idle,
// through fold, three squares, sigma^2, a divide for sigma^2/r^2, five fixed-point
// products, a second divide for the force scale, three products for the components,
// then the load into the output stage. Each 64x64 product is four partial products on a
// single 32x32 multiplier; the two divides dominate and are cut short when the quotient
// saturates. A pair that fails the fold goes to the output stage straight from the fold,
// one beyond the cutoff or at zero distance straight from the check after the squares.
// Reset clears the sequencer, the energy sum and loads the register defaults.
// The output stage holds a finished beat while the next pair is worked; a pair finished
// while the previous beat is still stalled waits for it to go.

module lennard_jones_pair_force
  import ljpf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input pairs
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [191:0]         s_axis_tdata,  // first_x, first_y, first_z,
                                                   // second_x, second_y, second_z
  input  wire logic                 s_axis_tlast,
  // results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [207:0]              m_axis_tdata,  // force_x, force_y, force_z, energy_total
  output logic                      m_axis_tuser,  // within_cutoff
  output logic                      m_axis_tlast,
  // register writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  ljpf_state_e state_q, state_d;

  // configuration
  logic [31:0] box_q, sigma_q, eps_q, cut_q;

  // per-pair working registers
  logic [31:0] pa_q [3];
  logic [31:0] pb_q [3];
  logic        last_q;
  logic        dneg_q [3];
  logic [31:0] dmag_q [3];
  logic        ok_q;
  logic [63:0] sum_q;
  logic [1:0]  ax_q;
  logic        pend_q;
  logic [63:0] s2_q, q_q, t_q, sr6_q, sr12_q, g_q, fr_q;
  logic [47:0] frc_q [3];
  logic        fneg_q;
  logic [63:0] energy_q;

  // result stage
  logic         ov_q;
  logic [207:0] odata_q;
  logic         ouser_q, olast_q;

  // shared units
  logic         mul_start, div_start;
  logic [63:0]  mul_a, mul_b;
  logic [63:0]  div_hi, div_lo;
  logic         mul_done, div_done;
  logic [127:0] mul_prod;
  logic [63:0]  div_quo;
  logic [63:0]  mq;

  // folding
  logic signed [34:0] dfold [3];
  logic               fold_neg [3];
  logic [34:0]        fold_mag [3];
  logic               fold_ok;

  // derived values
  logic        eneg;
  logic [63:0] ediff, tw, fm;
  logic        fneg_c;
  logic        load_out;

  ljpf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ljpf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (div_hi),
    .num_lo_i (div_lo),
    .den_i    (sum_q),
    .done_o   (div_done),
    .quo_o    (div_quo)
  );

  assign mq = mulq_sat(mul_prod);

  // minimum image, one wrap at most per axis
  always_comb begin
    fold_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      logic signed [34:0] d, l;
      d = $signed({3'b0, pa_q[i]}) - $signed({3'b0, pb_q[i]});
      l = $signed({3'b0, box_q});
      if ((d <<< 1) > l) begin
        dfold[i] = d - l;
      end else if ((d <<< 1) < -l) begin
        dfold[i] = d + l;
      end else begin
        dfold[i] = d;
      end
      fold_neg[i] = dfold[i][34];
      fold_mag[i] = fold_neg[i] ? 35'(-dfold[i]) : 35'(dfold[i]);
      if (fold_mag[i][34:32] != '0) begin
        fold_ok = 1'b0;
      end
    end
  end

  always_comb begin
    eneg   = (sr12_q < sr6_q);
    ediff  = eneg ? (sr6_q - sr12_q) : (sr12_q - sr6_q);
    tw     = sat_x2(sr12_q);
    fneg_c = (tw < sr6_q);
    fm     = fneg_c ? (sr6_q - tw) : (tw - sr6_q);
  end

  // result stage may take a new beat when empty or draining this cycle
  assign load_out = (state_q == ST_DONE) && (!ov_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_FOLD;
      ST_FOLD: state_d = fold_ok ? ST_SQ : ST_DONE;
      ST_SQ:   if (pend_q && mul_done && ax_q == 2'd2) state_d = ST_CHK;
      ST_CHK: begin
        if (sum_q == '0 || sum_q > {cut_q, {FRAC_BITS{1'b0}}}) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_S2;
        end
      end
      ST_S2:   if (pend_q && mul_done) state_d = ST_DIV1;
      ST_DIV1: if (pend_q && div_done) state_d = ST_M1;
      ST_M1:   if (pend_q && mul_done) state_d = ST_M2;
      ST_M2:   if (pend_q && mul_done) state_d = ST_M3;
      ST_M3:   if (pend_q && mul_done) state_d = ST_EN;
      ST_EN:   if (pend_q && mul_done) state_d = ST_FM;
      ST_FM:   if (pend_q && mul_done) state_d = ST_DIV2;
      ST_DIV2: if (pend_q && div_done) state_d = ST_FRC;
      ST_FRC:  if (pend_q && mul_done && ax_q == 2'd2) state_d = ST_DONE;
      ST_DONE: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // unit control and operands
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_hi    = '0;
    div_lo    = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_start = !pend_q;
        mul_a     = {32'b0, dmag_q[ax_q]};
        mul_b     = {32'b0, dmag_q[ax_q]};
      end
      ST_S2: begin
        mul_start = !pend_q;
        mul_a     = {32'b0, sigma_q};
        mul_b     = {32'b0, sigma_q};
      end
      ST_DIV1: begin
        div_start = !pend_q;
        div_hi    = s2_q >> (64 - FRAC_BITS);
        div_lo    = s2_q << FRAC_BITS;
      end
      ST_M1: begin
        mul_start = !pend_q;
        mul_a     = q_q;
        mul_b     = q_q;
      end
      ST_M2: begin
        mul_start = !pend_q;
        mul_a     = t_q;
        mul_b     = q_q;
      end
      ST_M3: begin
        mul_start = !pend_q;
        mul_a     = sr6_q;
        mul_b     = sr6_q;
      end
      ST_EN: begin
        mul_start = !pend_q;
        mul_a     = {32'b0, eps_q};
        mul_b     = ediff;
      end
      ST_FM: begin
        mul_start = !pend_q;
        mul_a     = {32'b0, eps_q};
        mul_b     = fm;
      end
      ST_DIV2: begin
        div_start = !pend_q;
        div_hi    = g_q >> (64 - 2 * FRAC_BITS);
        div_lo    = g_q << (2 * FRAC_BITS);
      end
      ST_FRC: begin
        mul_start = !pend_q;
        mul_a     = fr_q;
        mul_b     = {32'b0, dmag_q[ax_q]};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= 1'b0;
      ax_q     <= '0;
      ov_q     <= 1'b0;
      energy_q <= '0;
      box_q    <= BOX_LENGTH_RST;
      sigma_q  <= SIGMA_RST;
      eps_q    <= EPSILON_RST;
      cut_q    <= CUTOFF_SQ_RST;
    end else begin
      state_q <= state_d;

      if (mul_start || div_start) begin
        pend_q <= 1'b1;
      end else if (pend_q && (mul_done || div_done)) begin
        pend_q <= 1'b0;
      end

      if (state_q == ST_FOLD) begin
        ax_q <= '0;
      end else if ((state_q == ST_SQ || state_q == ST_FRC) && pend_q && mul_done) begin
        ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
      end

      if (state_q == ST_EN && pend_q && mul_done) begin
        energy_q <= energy_add(energy_q, eneg, sat_x4(mq));
      end

      if (load_out) begin
        ov_q <= 1'b1;
        if (last_q) energy_q <= '0;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_BOX_LENGTH:     box_q   <= cfg_data_i;
          REG_SIGMA:          sigma_q <= cfg_data_i;
          REG_EPSILON:        eps_q   <= cfg_data_i;
          REG_CUTOFF_SQUARED: cut_q   <= cfg_data_i;
          default:            ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            pa_q[i] <= s_axis_tdata[32*i +: 32];
            pb_q[i] <= s_axis_tdata[96 + 32*i +: 32];
          end
          last_q <= s_axis_tlast;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 3; i++) begin
          dneg_q[i] <= fold_neg[i];
          dmag_q[i] <= fold_mag[i][31:0];
          frc_q[i]  <= '0;
        end
        ok_q  <= fold_ok;
        sum_q <= '0;
      end
      ST_SQ:   if (pend_q && mul_done) sum_q <= sat_add(sum_q, mul_prod[63:0]);
      ST_CHK:  ok_q <= !(sum_q == '0 || sum_q > {cut_q, {FRAC_BITS{1'b0}}});
      ST_S2:   if (pend_q && mul_done) s2_q <= mul_prod[63:0];
      ST_DIV1: if (pend_q && div_done) q_q <= div_quo;
      ST_M1:   if (pend_q && mul_done) t_q <= mq;
      ST_M2:   if (pend_q && mul_done) sr6_q <= mq;
      ST_M3:   if (pend_q && mul_done) sr12_q <= mq;
      ST_FM: begin
        if (pend_q && mul_done) begin
          g_q    <= sat_x24(mq);
          fneg_q <= fneg_c;
        end
      end
      ST_DIV2: if (pend_q && div_done) fr_q <= div_quo;
      ST_FRC: begin
        if (pend_q && mul_done) begin
          frc_q[ax_q] <= force_word(fneg_q != dneg_q[ax_q], mq);
        end
      end
      default: ;
    endcase

    if (load_out) begin
      odata_q <= {energy_q, frc_q[2], frc_q[1], frc_q[0]};
      ouser_q <= ok_q;
      olast_q <= last_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire
